### src/assert_macros.svh
// Assertion macros used by the descriptor block's output sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ZDD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zdd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ZDD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zdd assertion failed");

`endif

### src/zdd_pkg.sv
// Types, constants and the CRC-32 byte update for the data descriptor block.
`default_nettype none

package zdd_pkg;

   localparam logic [31:0] DescMarker   = 32'h08074b50;
   localparam logic [31:0] CrcInit      = 32'hffffffff;
   localparam logic [31:0] CrcPoly      = 32'hedb88320;
   localparam int          DescBytes    = 16;
   localparam int          DescIdxWidth = $clog2(DescBytes);
   localparam logic [DescIdxWidth-1:0] DescLastIdx = DescIdxWidth'(DescBytes - 1);

   // Word codes within the descriptor (upper bits of the byte index)
   localparam logic [1:0] WordMarker = 2'd0;
   localparam logic [1:0] WordCrc    = 2'd1;
   localparam logic [1:0] WordCsize  = 2'd2;
   localparam logic [1:0] WordUsize  = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_member;
   } zdd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_descriptor;
      logic       descriptor_last;
   } zdd_rsp_type;

   // One accepted request handed to the output sequencer
   typedef struct packed {
      logic        valid;
      logic        has_byte;
      logic        end_of_member;
      logic [7:0]  data;
      logic [31:0] crc;
      logic [31:0] size;
   } zdd_load_type;

   // Reflected CRC-32 register advanced by one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### src/zdd_emitter.sv
// Output sequencer: pass-through byte then the 16 descriptor bytes of one request.
`default_nettype none

`include "assert_macros.svh"

module zdd_emitter (
   input  logic                clock,
   input  logic                reset,
   input  zdd_pkg::zdd_load_type load,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output zdd_pkg::zdd_rsp_type rsp_payload
);
   import zdd_pkg::*;

   logic                    byte_pend_ff, byte_pend_in;
   logic                    desc_pend_ff, desc_pend_in;
   logic [DescIdxWidth-1:0] idx_ff, idx_in;
   logic [7:0]              data_ff, data_in;
   logic [31:0]             crc_ff, crc_in;
   logic [31:0]             size_ff, size_in;

   logic                    busy;
   logic                    take;
   logic                    last_step;
   logic                    pass_out;
   logic [31:0]             word;

   // Handshake on the result side
   assign busy      = byte_pend_ff | desc_pend_ff;
   assign take      = busy && !rsp_stall;
   assign last_step = byte_pend_ff ? !desc_pend_ff : (idx_ff == DescLastIdx);
   assign load_ready = !busy || (take && last_step);
   assign rsp_valid = busy;
   assign pass_out  = rsp_valid && !rsp_payload.is_descriptor;

   // Select the descriptor word for the current byte index
   always_comb begin
      unique case (idx_ff[DescIdxWidth-1 -: 2])
         WordMarker: word = DescMarker;
         WordCrc:    word = crc_ff;
         WordCsize:  word = size_ff;
         WordUsize:  word = size_ff;
         default:    word = DescMarker;
      endcase
   end

   // Drive the result: pending data byte first, then descriptor bytes
   always_comb begin
      if (byte_pend_ff) begin
         rsp_payload.out_byte        = data_ff;
         rsp_payload.is_descriptor   = 1'b0;
         rsp_payload.descriptor_last = 1'b0;
      end else begin
         rsp_payload.out_byte        = word[{idx_ff[1:0], 3'b000} +: 8];
         rsp_payload.is_descriptor   = 1'b1;
         rsp_payload.descriptor_last = (idx_ff == DescLastIdx);
      end
   end

   // Advance on each taken result, reload on a new request
   always_comb begin
      byte_pend_in = byte_pend_ff;
      desc_pend_in = desc_pend_ff;
      idx_in       = idx_ff;
      data_in      = data_ff;
      crc_in       = crc_ff;
      size_in      = size_ff;
      if (take) begin
         if (byte_pend_ff) begin
            byte_pend_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == DescLastIdx) begin
               desc_pend_in = 1'b0;
            end
         end
      end
      if (load.valid) begin
         byte_pend_in = load.has_byte;
         desc_pend_in = load.end_of_member;
         idx_in       = '0;
         data_in      = load.data;
         crc_in       = load.crc;
         size_in      = load.size;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pend_ff <= 1'b0;
         desc_pend_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         byte_pend_ff <= byte_pend_in;
         desc_pend_ff <= desc_pend_in;
         idx_ff       <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      crc_ff  <= crc_in;
      size_ff <= size_in;
   end

   `ZDD_ASSERT_IMP(a_load_when_ready, clock, reset, load.valid, load_ready)
   `ZDD_ASSERT_NXT(a_byte_first, clock, reset, load.valid && load.has_byte, pass_out)
   `ZDD_ASSERT_NXT(a_last_wraps, clock, reset, take && rsp_payload.descriptor_last, idx_ff == '0)
   `ZDD_ASSERT_IMP(a_pass_at_start, clock, reset, pass_out, idx_ff == '0)

endmodule

`default_nettype wire

### src/zip_data_descriptor_crc32.sv
// Stored-member pass-through with CRC-32 and size data descriptor.
//
// Request channel: req_valid, req_stall, req_payload {data_byte, has_byte,
// end_of_member}. Result channel: rsp_valid, rsp_stall, rsp_payload
// {out_byte, is_descriptor, descriptor_last}.
// A request with has_byte gives its data byte on the result channel in the
// cycle after it is accepted. A request with end_of_member then gives the
// 16 descriptor bytes (marker, CRC-32, compressed size, uncompressed size,
// each little-endian), one per cycle while the receiver does not stall; the
// running CRC and count restart. Throughput: one data-only request per cycle
// while the receiver does not stall. A request closing a member occupies
// the output sequencer until its data byte, if any, and 16 descriptor bytes
// are taken; the request side stalls until its final result is being taken.
// A request with neither flag gives nothing and changes nothing. When the
// receiver stalls, the current result holds and the request side stalls once
// the sequencer holds unfinished work. Synchronous reset sets the CRC to all
// ones, the count to zero and drops any result not yet delivered.
`default_nettype none

module zip_data_descriptor_crc32 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  zdd_pkg::zdd_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output zdd_pkg::zdd_rsp_type rsp_payload
);
   import zdd_pkg::*;

   logic [31:0]  crc_ff, crc_in;
   logic [31:0]  count_ff, count_in;
   logic         req_take;
   logic         load_ready;
   logic [31:0]  crc_upd;
   logic [31:0]  count_upd;
   zdd_load_type load;

   assign req_stall = !load_ready;
   assign req_take  = req_valid && !req_stall;

   // Fold the byte into the running CRC and count
   assign crc_upd   = req_payload.has_byte ? crc_byte(crc_ff, req_payload.data_byte) : crc_ff;
   assign count_upd = req_payload.has_byte ? count_ff + 32'd1 : count_ff;

   // Hand the request to the sequencer with its descriptor values
   always_comb begin
      load.valid         = req_take && (req_payload.has_byte || req_payload.end_of_member);
      load.has_byte      = req_payload.has_byte;
      load.end_of_member = req_payload.end_of_member;
      load.data          = req_payload.data_byte;
      load.crc           = ~crc_upd;
      load.size          = count_upd;
   end

   // Restart at the end of a member, otherwise keep the running values
   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      if (req_take) begin
         if (req_payload.end_of_member) begin
            crc_in   = CrcInit;
            count_in = '0;
         end else begin
            crc_in   = crc_upd;
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CrcInit;
         count_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

   zdd_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .load_ready  (load_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking bench for the stored-member pass-through and data descriptor block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import zdd_pkg::*;

   localparam int Period      = 4;
   localparam int RandomItems = 410;
   localparam int SettleWait  = 40;
   localparam int RunLimit    = 2000000;

   typedef struct {
      zdd_req_type req;
      bit          hold_for_drain;
   } staged_request_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   zdd_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   zdd_rsp_type rsp_payload;

   staged_request_type pending[$];
   zdd_rsp_type   out_bytes_due[$];
   logic [31:0]   crc_table [256];
   logic [31:0]   crc_run;
   logic [31:0]   byte_count;
   int            send_gap;
   int            stall_left;
   int            cycle_count;
   int            errors;
   bit            drain_req;

   zip_data_descriptor_crc32 DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #(Period / 2) clock = ~clock;

   // Table-driven CRC-32 step, reflected, one byte
   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
      return (c >> 8) ^ crc_table[c[7:0] ^ d];
   endfunction

   // Mostly short gaps, a few long ones, none at all during quiet stretches
   function automatic int idle_length(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic note_failure(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
      errors++;
   endtask

   // Queue one request for the driver; a pending drain mark rides on it
   task automatic stage(input logic [7:0] d, input logic has, input logic eom);
      staged_request_type s;
      s.req.data_byte     = d;
      s.req.has_byte      = has;
      s.req.end_of_member = eom;
      s.hold_for_drain    = drain_req;
      drain_req           = 1'b0;
      pending.push_back(s);
   endtask

   // Work out the output bytes that one accepted request causes
   task automatic account_request(input zdd_req_type r);
      zdd_rsp_type  o;
      logic [127:0] desc;
      if (r.has_byte) begin
         o.out_byte        = r.data_byte;
         o.is_descriptor   = 1'b0;
         o.descriptor_last = 1'b0;
         out_bytes_due.push_back(o);
         crc_run    = crc_next(crc_run, r.data_byte);
         byte_count = byte_count + 32'd1;
      end
      if (r.end_of_member) begin
         desc = {byte_count, byte_count, ~crc_run, DescMarker};
         for (int i = 0; i < DescBytes; i++) begin
            o.out_byte        = desc[8*i +: 8];
            o.is_descriptor   = 1'b1;
            o.descriptor_last = (i == DescBytes - 1);
            out_bytes_due.push_back(o);
         end
         crc_run    = CrcInit;
         byte_count = '0;
      end
   endtask

   // Driver: take accepted requests, then present the next staged one
   always @(posedge clock) begin
      staged_request_type nx;
      logic          drive_valid;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         drive_valid = req_valid;
         if (req_valid && !req_stall) begin
            account_request(req_payload);
            drive_valid = 1'b0;
         end
         if (!drive_valid) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending.size() != 0 &&
                         (!pending[0].hold_for_drain || out_bytes_due.size() == 0)) begin
               nx = pending.pop_front();
               req_payload <= nx.req;
               drive_valid = 1'b1;
               send_gap = idle_length(cycle_count[8:7] == 2'b11);
            end
         end
         req_valid <= drive_valid;
      end
   end

   // Monitor: check taken results against the oldest due byte, drive stall
   always @(posedge clock) begin
      zdd_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (out_bytes_due.size() == 0) begin
               note_failure("result with none due, out_byte", int'(rsp_payload.out_byte), 0);
            end else begin
               want = out_bytes_due.pop_front();
               if (rsp_payload.out_byte !== want.out_byte)
                  note_failure("out_byte", int'(rsp_payload.out_byte), int'(want.out_byte));
               if (rsp_payload.is_descriptor !== want.is_descriptor)
                  note_failure("is_descriptor", int'(rsp_payload.is_descriptor),
                               int'(want.is_descriptor));
               if (rsp_payload.descriptor_last !== want.descriptor_last)
                  note_failure("descriptor_last", int'(rsp_payload.descriptor_last),
                               int'(want.descriptor_last));
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = idle_length(cycle_count[9:8] == 2'b01);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RunLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [31:0] v;
      int          produced;
      int          len;
      int          r;
      bit          close_with_byte;
      bit          drained_once;
      string       digits;

      errors       = 0;
      cycle_count  = 0;
      drain_req    = 1'b0;
      drained_once = 1'b0;
      crc_run      = CrcInit;
      byte_count   = '0;
      for (int i = 0; i < 256; i++) begin
         v = i;
         for (int b = 0; b < 8; b++) v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
         crc_table[i] = v;
      end

      // Directed: empty member first, then idle, extremes and combined close
      stage(8'h00, 1'b0, 1'b1);
      stage(8'hff, 1'b0, 1'b0);
      stage(8'h00, 1'b1, 1'b0);
      stage(8'h00, 1'b0, 1'b1);
      stage(8'hff, 1'b1, 1'b1);
      digits = "123456789";
      for (int i = 0; i < digits.len(); i++) stage(digits[i], 1'b1, 1'b0);
      stage(8'h00, 1'b0, 1'b1);
      stage(8'h55, 1'b1, 1'b0);
      stage(8'haa, 1'b1, 1'b0);
      stage(8'hff, 1'b0, 1'b0);
      stage(8'h00, 1'b0, 1'b1);
      // back-to-back empty members
      stage(8'h3c, 1'b0, 1'b1);
      stage(8'hc3, 1'b0, 1'b1);

      // Random members with random contents and some idle noise
      produced = 0;
      while (produced < RandomItems) begin
         if (!drained_once && produced >= RandomItems / 2) begin
            drain_req    = 1'b1;
            drained_once = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 8)       len = 0;
         else if (r < 80) len = $urandom_range(1, 12);
         else if (r < 97) len = $urandom_range(13, 40);
         else             len = $urandom_range(60, 120);
         close_with_byte = 1'($urandom_range(0, 1));
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               stage(8'($urandom_range(0, 255)), 1'b0, 1'b0);
               produced++;
            end
            stage(8'($urandom_range(0, 255)), 1'b1, close_with_byte && (i == len - 1));
            produced++;
         end
         if (len == 0 || !close_with_byte) begin
            stage(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            produced++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid) @(posedge clock);
      while (out_bytes_due.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
